[hdl/spi_register_slave_responder_core_assert.svh]
// Assertion macros shared by the SPI register slave responder RTL.
// Each macro expects signals clk and rst in the including scope.
`ifndef SPI_REGISTER_SLAVE_RESPONDER_CORE_ASSERT_SVH
`define SPI_REGISTER_SLAVE_RESPONDER_CORE_ASSERT_SVH

// Invariant checked at every rising clock edge outside reset
`define SRSR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication checked outside reset
`define SRSR_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/srsr_pkg.sv]
// Package for the SPI register slave responder: item types, address codes,
// constants and parameter defaults. No dependencies.
package srsr_pkg;

  // Parameter defaults
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SONAR_COUNT_DEF = 4;

  // Command decode
  localparam logic [7:0] ADDR_MASK   = 8'h7F;
  localparam logic [7:0] STATUS_BYTE = 8'h55;
  localparam logic [3:0] MOTOR_BYTES = 4'd9;

  // Register addresses
  localparam logic [6:0] ADDR_SONAR      = 7'd1;
  localparam logic [6:0] ADDR_SPEED      = 7'd2;
  localparam logic [6:0] ADDR_POSITION   = 7'd3;
  localparam logic [6:0] ADDR_MOTORS     = 7'd4;
  localparam logic [6:0] ADDR_SET_STATUS = 7'd5;
  localparam logic [6:0] ADDR_GET_STATUS = 7'd6;

  // Item operations
  localparam logic OP_RX  = 1'b0;
  localparam logic OP_POP = 1'b1;

  // Longest burst of bytes one command queues (position read)
  localparam int MAX_PUSH = 8;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_byte;
    logic [15:0] sonar_0;
    logic [15:0] sonar_1;
    logic [15:0] sonar_2;
    logic [15:0] sonar_3;
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic        left_reverse;
    logic        right_reverse;
    logic [31:0] left_position;
    logic [31:0] right_position;
  } srsr_in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        drive_valid;
    logic [31:0] drive_word;
    logic [1:0]  drive_flags;
    logic        dropped;
  } srsr_out_t;

endpackage

[hdl/srsr_stream_if.sv]
// Valid/ready stream interface used for the responder's item channels.
// Payload type is a parameter; depends on nothing else.
interface srsr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/srsr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the responder's transmit queue storage.
module srsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/spi_register_slave_responder_core.sv]
// SPI register slave responder top level.
// Depends on srsr_pkg, srsr_stream_if, srsr_ram and the assertion macro header.

// Takes one item at a time on cmd and returns exactly one result beat on rsp for
// each. A received byte with no write bytes pending and an empty transmit queue is a
// command: read addresses copy the sensor fields of that item, or the status byte,
// into the queue, low byte first, one byte per cycle through the queue RAM write port.
// A pop reads the queue RAM at the read pointer. The result sits in an output
// register, so the next item is taken while an earlier result still waits on rsp.
module spi_register_slave_responder_core #(
  parameter int QUEUE_DEPTH = srsr_pkg::QUEUE_DEPTH_DEF,
  parameter int SONAR_COUNT = srsr_pkg::SONAR_COUNT_DEF
) (
  input logic           clk,
  input logic           rst,
  srsr_stream_if.sink   cmd,
  srsr_stream_if.source rsp
);
  import srsr_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]      state;
  logic [PtrW-1:0] read_ptr;
  logic [PtrW-1:0] write_ptr;
  logic [CntW-1:0] fill_count;
  logic [3:0]      bytes_expected;
  logic [6:0]      active_address;
  logic [7:0]      drive_direction;
  logic [31:0]     word_accum;

  // Burst staged for the queue and its progress
  logic [MAX_PUSH-1:0][7:0] push_list;
  logic [MAX_PUSH-1:0][7:0] push_list_next;
  logic [3:0]               push_count_next;
  logic [3:0]               push_left;
  logic [2:0]               push_idx;

  // Pending result and output register
  srsr_out_t res;
  srsr_out_t res_first;
  srsr_out_t out_data;
  logic      out_valid;

  // Queue RAM port signals
  logic            ram_we;
  logic [7:0]      ram_rdata;
  logic            cmd_fire;
  logic            out_free;
  logic [6:0]      rx_addr;
  logic [1:0]      lane;
  logic [31:0]     acc_next;
  logic [15:0]     sonar [4];
  logic [CntW-1:0] ptr_gap;
  logic            ptr_ok;
  logic            cmd_start;
  logic            both_kinds;

  srsr_in_t item;

  assign item     = cmd.payload;
  assign cmd.ready = !rst && (state == S_IDLE);
  assign cmd_fire = cmd.valid && cmd.ready;
  assign out_free = !out_valid || rsp.ready;
  assign rx_addr  = 7'(item.rx_byte & ADDR_MASK);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  assign sonar[0] = item.sonar_0;
  assign sonar[1] = item.sonar_1;
  assign sonar[2] = item.sonar_2;
  assign sonar[3] = item.sonar_3;

  // Byte burst a read command queues, low byte first
  always_comb begin
    push_list_next  = '0;
    push_count_next = '0;
    case (rx_addr)
      ADDR_SONAR: begin
        for (int i = 0; i < SONAR_COUNT; i++) begin
          push_list_next[2*i]   = sonar[i][7:0];
          push_list_next[2*i+1] = sonar[i][15:8];
        end
        push_count_next = 4'(2 * SONAR_COUNT);
      end
      ADDR_SPEED: begin
        push_list_next[0] = {6'd0, item.right_reverse, item.left_reverse};
        push_list_next[1] = item.left_speed[7:0];
        push_list_next[2] = item.left_speed[15:8];
        push_list_next[3] = item.right_speed[7:0];
        push_list_next[4] = item.right_speed[15:8];
        push_count_next   = 4'd5;
      end
      ADDR_POSITION: begin
        push_list_next[3:0] = item.left_position;
        push_list_next[7:4] = item.right_position;
        push_count_next     = 4'd8;
      end
      ADDR_GET_STATUS: begin
        push_list_next[0] = STATUS_BYTE;
        push_count_next   = 4'd1;
      end
      default: begin
        push_count_next = '0;
      end
    endcase
  end

  // Motor word assembly: byte lane follows the remaining count
  assign lane     = 2'(4'd8 - bytes_expected);
  assign acc_next = word_accum | (32'(item.rx_byte) << {lane, 3'b000});

  // Reply fields known at the accepting edge
  always_comb begin
    res_first = '0;
    if (item.operation == OP_POP) begin
      res_first.tx_valid = (fill_count != '0);
    end else if (active_address == ADDR_MOTORS &&
                 (bytes_expected == 4'd5 || bytes_expected == 4'd1)) begin
      res_first.drive_valid = 1'b1;
      res_first.drive_word  = acc_next;
      res_first.drive_flags = (bytes_expected == 4'd5) ?
                              {drive_direction[0], 1'b0} :
                              {drive_direction[1], 1'b1};
    end
  end

  assign ram_we = (state == S_PUSH) && (fill_count < CntFull);

  srsr_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_tx_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_ptr),
    .wdata(push_list[push_idx]),
    .raddr(read_ptr),
    .rdata(ram_rdata)
  );

  // Output register valid: set when a result is loaded, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Control sequencer and queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      read_ptr        <= '0;
      write_ptr       <= '0;
      fill_count      <= '0;
      bytes_expected  <= '0;
      active_address  <= ADDR_SONAR;
      drive_direction <= '0;
      word_accum      <= '0;
      push_left       <= '0;
      push_idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            res <= res_first;
            if (item.operation == OP_POP) begin
              if (fill_count != '0) begin
                // RAM already reads read_ptr at this edge
                read_ptr   <= (read_ptr == PtrLast) ? '0 : read_ptr + 1'b1;
                fill_count <= fill_count - 1'b1;
                state      <= S_POP;
              end else begin
                state <= S_FIN;
              end
            end else if (bytes_expected == '0 && fill_count == '0) begin
              active_address <= rx_addr;
              push_list      <= push_list_next;
              push_left      <= push_count_next;
              push_idx       <= '0;
              state          <= (push_count_next != '0) ? S_PUSH : S_FIN;
              if (rx_addr == ADDR_MOTORS) begin
                bytes_expected <= MOTOR_BYTES;
              end else if (rx_addr == ADDR_SET_STATUS) begin
                bytes_expected <= 4'd1;
              end
            end else begin
              state <= S_FIN;
              if (bytes_expected != '0) begin
                bytes_expected <= bytes_expected - 1'b1;
                if (active_address == ADDR_MOTORS) begin
                  if (bytes_expected >= MOTOR_BYTES) begin
                    drive_direction <= item.rx_byte;
                    word_accum      <= '0;
                  end else if (bytes_expected == 4'd5 || bytes_expected == 4'd1) begin
                    word_accum <= '0;
                  end else begin
                    word_accum <= acc_next;
                  end
                end
              end
            end
          end
        end
        S_PUSH: begin
          if (ram_we) begin
            write_ptr  <= (write_ptr == PtrLast) ? '0 : write_ptr + 1'b1;
            fill_count <= fill_count + 1'b1;
          end else begin
            res.dropped <= 1'b1;
          end
          push_idx  <= push_idx + 1'b1;
          push_left <= push_left - 1'b1;
          if (push_left == 4'd1) begin
            state <= S_FIN;
          end
        end
        S_POP: begin
          res.tx_byte <= ram_rdata;
          state       <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Occupancy implied by the pointers, for checking against fill_count
  assign ptr_gap = (write_ptr >= read_ptr) ? CntW'(write_ptr - read_ptr) :
                   CntW'(write_ptr) + CntFull - CntW'(read_ptr);
  assign ptr_ok  = (ptr_gap == fill_count) || (fill_count == CntFull && ptr_gap == '0);
  assign cmd_start = cmd_fire && item.operation == OP_RX &&
                     bytes_expected == '0 && fill_count == '0;
  assign both_kinds = out_data.tx_valid && out_data.drive_valid;

  `include "spi_register_slave_responder_core_assert.svh"

  `SRSR_ASSERT_ALWAYS(a_fill_bound, fill_count <= CntFull, "fill count above queue depth")
  `SRSR_ASSERT_ALWAYS(a_ptr_track, ptr_ok, "pointers disagree with fill count")
  `SRSR_ASSERT_IMPLIES(a_one_kind, out_valid, !both_kinds, "byte and motor word in one beat")
  `SRSR_ASSERT_IMPLIES(a_push_empty_start, cmd_start, write_ptr == read_ptr, "pointers apart")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for spi_register_slave_responder_core: drives received-byte and pop beats,
// predicts the reply to each beat and checks the replies in order.
// Depends on srsr_pkg, srsr_stream_if and the responder RTL.
module tb_top;
  import srsr_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int SONARS      = SONAR_COUNT_DEF;
  localparam int ITEM_TARGET = 1800;
  localparam int DRAIN_WAIT  = 20;

  typedef enum int {
    STALL_NONE,
    STALL_PERIODIC,
    STALL_RANDOM,
    STALL_LONG
  } stall_mode_t;

  // Mirror of the transmit queue and motor word state, plus the replies still owed
  class reply_scoreboard;
    logic [7:0]  tx_mem [DEPTH];
    int          rd_idx;
    int          wr_idx;
    int          fill;
    int          data_left;
    logic [6:0]  cur_addr;
    logic [7:0]  dir_byte;
    logic [31:0] motor_word;
    bit          push_lost;
    srsr_out_t   replies_due[$];
    int          errors;

    function new();
      rd_idx     = 0;
      wr_idx     = 0;
      fill       = 0;
      data_left  = 0;
      cur_addr   = ADDR_SONAR;
      dir_byte   = '0;
      motor_word = '0;
      push_lost  = 1'b0;
      errors     = 0;
      foreach (tx_mem[i]) tx_mem[i] = '0;
    endfunction

    function void push_byte(logic [7:0] b);
      if (fill >= DEPTH) begin
        push_lost = 1'b1;
      end else begin
        tx_mem[wr_idx] = b;
        wr_idx = (wr_idx + 1) % DEPTH;
        fill++;
      end
    endfunction

    // Queue a value low byte first
    function void push_le(logic [31:0] v, int nbytes);
      for (int i = 0; i < nbytes; i++) push_byte(v[8*i +: 8]);
    endfunction

    function srsr_out_t compute_reply(srsr_in_t it);
      srsr_out_t   r;
      logic [15:0] sonar [4];
      r         = '0;
      push_lost = 1'b0;
      sonar     = '{it.sonar_0, it.sonar_1, it.sonar_2, it.sonar_3};
      if (it.operation == OP_POP) begin
        if (fill > 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = tx_mem[rd_idx];
          rd_idx     = (rd_idx + 1) % DEPTH;
          fill--;
        end
      end else if (data_left == 0 && fill == 0) begin
        // command byte
        cur_addr = 7'(it.rx_byte & ADDR_MASK);
        case (cur_addr)
          ADDR_SONAR: begin
            for (int i = 0; i < SONARS && i < 4; i++) push_le(32'(sonar[i]), 2);
          end
          ADDR_SPEED: begin
            push_byte({6'd0, it.right_reverse, it.left_reverse});
            push_le(32'(it.left_speed), 2);
            push_le(32'(it.right_speed), 2);
          end
          ADDR_POSITION: begin
            push_le(it.left_position, 4);
            push_le(it.right_position, 4);
          end
          ADDR_MOTORS:     data_left = int'(MOTOR_BYTES);
          ADDR_SET_STATUS: data_left = 1;
          ADDR_GET_STATUS: push_byte(STATUS_BYTE);
          default: ;
        endcase
      end else if (data_left != 0) begin
        // write data; for a motor write: direction byte, then left word, then right word
        if (cur_addr == ADDR_MOTORS) begin
          if (data_left >= MOTOR_BYTES) begin
            dir_byte   = it.rx_byte;
            motor_word = '0;
          end else if (data_left >= 5) begin
            motor_word |= 32'(it.rx_byte) << (8 * ((8 - data_left) & 3));
            if (data_left == 5) begin
              r.drive_valid = 1'b1;
              r.drive_word  = motor_word;
              r.drive_flags = {dir_byte[0], 1'b0};
              motor_word    = '0;
            end
          end else begin
            motor_word |= 32'(it.rx_byte) << (8 * ((4 - data_left) & 3));
            if (data_left == 1) begin
              r.drive_valid = 1'b1;
              r.drive_word  = motor_word;
              r.drive_flags = {dir_byte[1], 1'b1};
              motor_word    = '0;
            end
          end
        end
        data_left--;
      end
      r.dropped = push_lost;
      return r;
    endfunction

    function void note_input(srsr_in_t it);
      replies_due.push_back(compute_reply(it));
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(srsr_out_t got);
      srsr_out_t want;
      if (replies_due.size() == 0) begin
        $error("reply beat with none outstanding: %h", got);
        errors++;
      end else begin
        want = replies_due.pop_front();
        compare("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
        compare("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
        compare("drive_valid", 32'(want.drive_valid), 32'(got.drive_valid));
        compare("drive_word", want.drive_word, got.drive_word);
        compare("drive_flags", 32'(want.drive_flags), 32'(got.drive_flags));
        compare("dropped", 32'(want.dropped), 32'(got.dropped));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  srsr_stream_if #(.payload_t(srsr_in_t))  cmd_if ();
  srsr_stream_if #(.payload_t(srsr_out_t)) rsp_if ();

  reply_scoreboard board = new();

  int          counted;
  int          burst_left;
  bit          drained_mid;
  stall_mode_t stall_mode;
  int          stall_left;
  int          stall_tick;

  spi_register_slave_responder_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reply side: check the accepted beat, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.payload);
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     rsp_if.ready <= 1'b1;
      STALL_PERIODIC: rsp_if.ready <= (stall_tick % 3) != 0;
      STALL_RANDOM:   rsp_if.ready <= 1'($urandom_range(0, 1));
      default:        rsp_if.ready <= (stall_tick % 24) < 8;
    endcase
  end

  // Random sensor fields; now and then all zeros or all ones
  function automatic srsr_in_t make_item(logic op, logic [7:0] rx);
    srsr_in_t it;
    int       pick;
    pick = $urandom_range(0, 15);
    for (int i = 0; i < $bits(it); i++) it[i] = 1'($urandom_range(0, 1));
    if (pick == 0) it = '0;
    else if (pick == 1) it = '1;
    it.operation = op;
    it.rx_byte   = rx;
    return it;
  endfunction

  // Sender bursts: at a burst boundary drop valid for a random gap
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(srsr_in_t it, bit counts);
    pace_sender();
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= it;
    do @(posedge clk); while (!cmd_if.ready);
    board.note_input(it);
    if (counts) counted++;
  endtask

  // Hold off until every outstanding reply has come back
  task automatic wait_replies();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (board.replies_due.size() != 0);
  endtask

  // Pop until the queue is empty, with stray bytes mixed in if asked
  task automatic pop_all(bit with_noise);
    while (board.fill > 0) begin
      if (with_noise && $urandom_range(0, 5) == 0) begin
        send_item(make_item(OP_RX, 8'($urandom)), 0);
      end
      send_item(make_item(OP_POP, 8'($urandom)), 1);
    end
  endtask

  task automatic run_directed();
    srsr_in_t it;
    // pop from an empty queue
    send_item(make_item(OP_POP, 8'h00), 1);
    // sonar read with every sensor bit set
    it           = '1;
    it.operation = OP_RX;
    it.rx_byte   = {1'b0, ADDR_SONAR};
    send_item(it, 1);
    // byte arriving while the queue still holds data is ignored
    send_item(make_item(OP_RX, {1'b0, ADDR_GET_STATUS}), 1);
    pop_all(0);
    // status read with the top command bit set
    send_item(make_item(OP_RX, {1'b1, ADDR_GET_STATUS}), 1);
    send_item(make_item(OP_POP, 8'($urandom)), 1);
    // motor write: both direction bits, all-ones left word, zero right word
    send_item(make_item(OP_RX, {1'b0, ADDR_MOTORS}), 1);
    send_item(make_item(OP_RX, 8'h03), 1);
    repeat (4) send_item(make_item(OP_RX, 8'hFF), 1);
    repeat (4) send_item(make_item(OP_RX, 8'h00), 1);
    // set status swallows a byte that looks like a command
    send_item(make_item(OP_RX, {1'b0, ADDR_SET_STATUS}), 1);
    send_item(make_item(OP_RX, {1'b0, ADDR_MOTORS}), 1);
    // highest, undecoded address
    send_item(make_item(OP_RX, 8'h7F), 1);
  endtask

  task automatic run_sequence();
    int         kind;
    int         nbytes;
    logic [6:0] addr;
    logic [6:0] reads [4];
    kind  = $urandom_range(0, 99);
    reads = '{ADDR_SONAR, ADDR_SPEED, ADDR_POSITION, ADDR_GET_STATUS};
    if (kind < 45) begin
      // sensor read, then drain the queue
      send_item(make_item(OP_RX, {1'($urandom), reads[$urandom_range(0, 3)]}), 1);
      pop_all(1);
      if ($urandom_range(0, 3) == 0) send_item(make_item(OP_POP, 8'($urandom)), 1);
    end else if (kind < 72) begin
      // motor write, sometimes cut short
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : int'(MOTOR_BYTES);
      send_item(make_item(OP_RX, {1'($urandom), ADDR_MOTORS}), 1);
      repeat (nbytes) begin
        if ($urandom_range(0, 7) == 0) send_item(make_item(OP_POP, 8'($urandom)), 1);
        send_item(make_item(OP_RX, 8'($urandom)), 1);
      end
    end else if (kind < 84) begin
      send_item(make_item(OP_RX, {1'($urandom), ADDR_SET_STATUS}), 1);
      send_item(make_item(OP_RX, 8'($urandom)), 1);
    end else if (kind < 92) begin
      // address outside the decoded range
      addr = $urandom_range(0, 1) ? 7'($urandom_range(7, 127)) : 7'd0;
      send_item(make_item(OP_RX, {1'($urandom), addr}), 1);
    end else begin
      // loose pops and bytes
      repeat ($urandom_range(1, 4)) send_item(make_item(1'($urandom), 8'($urandom)), 0);
    end
  endtask

  initial begin
    rst            = 1'b1;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    wait_replies();
    while (counted < ITEM_TARGET) begin
      run_sequence();
      if (!drained_mid && counted >= ITEM_TARGET / 2) begin
        wait_replies();
        drained_mid = 1'b1;
      end
    end
    wait_replies();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0 && board.replies_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
